>>> rtl/core/adsr_pkg.sv
// Shared widths, register indexes, phase codes and pipeline beat types
// for the linear ADSR envelope level block. No dependencies.
package adsr_pkg;

  localparam int TIME_BITS     = 24;
  localparam int LEVEL_BITS    = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS;
  localparam int PHASE_BITS    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK_LEN  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_LEN   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_LEN = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_LEVEL = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PEAK_LEVEL  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_LEVEL  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_FINAL_LEVEL = 3'd6;

  // envelope phase codes
  localparam logic [PHASE_BITS-1:0] PH_ATTACK  = 3'd0;
  localparam logic [PHASE_BITS-1:0] PH_DECAY   = 3'd1;
  localparam logic [PHASE_BITS-1:0] PH_SUSTAIN = 3'd2;
  localparam logic [PHASE_BITS-1:0] PH_RELEASE = 3'd3;
  localparam logic [PHASE_BITS-1:0] PH_DONE    = 3'd4;

  // register reset values
  localparam logic [TIME_BITS-1:0]  RST_SEG_LEN = TIME_BITS'(480);
  localparam logic [LEVEL_BITS-1:0] RST_START   = '0;
  localparam logic [LEVEL_BITS-1:0] RST_PEAK    = '1;
  localparam logic [LEVEL_BITS-1:0] RST_HOLD    = LEVEL_BITS'(3) << (LEVEL_BITS - 2);
  localparam logic [LEVEL_BITS-1:0] RST_FINAL   = '0;

  typedef struct packed {
    logic [TIME_BITS-1:0]  attack_len;
    logic [TIME_BITS-1:0]  decay_len;
    logic [TIME_BITS-1:0]  release_len;
    logic [LEVEL_BITS-1:0] start_level;
    logic [LEVEL_BITS-1:0] peak_level;
    logic [LEVEL_BITS-1:0] hold_level;
    logic [LEVEL_BITS-1:0] final_level;
  } cfg_t;

  // sideband carried alongside the divider
  typedef struct packed {
    logic                  bypass;   // level is fixed, quotient unused
    logic                  down;     // ramp falls from its start level
    logic [PHASE_BITS-1:0] phase;
    logic [LEVEL_BITS-1:0] base;     // ramp start level, or the fixed level
  } side_t;

  // one beat in the divider cell chain
  typedef struct packed {
    logic [TIME_BITS-1:0]  rem;      // partial remainder, below den except in bypass beats
    logic [LEVEL_BITS-1:0] low;      // dividend bits not yet shifted in
    logic [LEVEL_BITS-1:0] quo;      // quotient bits so far
    logic [TIME_BITS-1:0]  den;
    side_t                 side;
  } cell_t;

endpackage

>>> rtl/core/adsr_setup.sv
// Phase decode and ramp product: two registered stages feeding the divider.
// Depends on adsr_pkg.
module adsr_setup (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            acc,
  input  logic [adsr_pkg::TIME_BITS-1:0]  elapsed,
  input  logic                            released_flag,
  input  logic [adsr_pkg::TIME_BITS-1:0]  release_offset,
  input  adsr_pkg::cfg_t                  cfg,
  output logic                            valid,
  output adsr_pkg::cell_t                 beat
);
  import adsr_pkg::*;

  logic                    in_ad;
  logic                    in_att;
  logic [TIME_BITS:0]      sum_ad;
  logic [TIME_BITS-1:0]    rel_t;
  logic                    rel_run;

  side_t                   side_nxt, side_r;
  logic [LEVEL_BITS-1:0]   to_lvl;
  logic [LEVEL_BITS-1:0]   span_nxt, span_r;
  logic [TIME_BITS-1:0]    num_nxt, num_r;
  logic [TIME_BITS-1:0]    den_nxt, den_r;
  logic                    v1_r;

  logic [LEVEL_BITS+TIME_BITS-1:0] prod;
  cell_t                   beat_r;
  logic                    v2_r;

  // segment boundaries
  assign sum_ad  = {1'b0, cfg.attack_len} + {1'b0, cfg.decay_len};
  assign in_ad   = {1'b0, elapsed} <= sum_ad;
  assign in_att  = elapsed <= cfg.attack_len;
  assign rel_t   = (elapsed > release_offset) ? elapsed - release_offset : '0;
  assign rel_run = rel_t < cfg.release_len;

  // pick the segment's end points, numerator and length
  always_comb begin
    side_nxt        = '0;
    to_lvl          = '0;
    num_nxt         = '0;
    den_nxt         = '0;
    priority if (in_ad && in_att) begin
      side_nxt.phase  = PH_ATTACK;
      side_nxt.bypass = (cfg.attack_len == '0);
      side_nxt.base   = side_nxt.bypass ? cfg.peak_level : cfg.start_level;
      to_lvl          = cfg.peak_level;
      num_nxt         = elapsed;
      den_nxt         = cfg.attack_len;
    end else if (in_ad) begin
      side_nxt.phase  = PH_DECAY;
      side_nxt.base   = cfg.peak_level;
      to_lvl          = cfg.hold_level;
      num_nxt         = elapsed - cfg.attack_len;
      den_nxt         = cfg.decay_len;
    end else if (released_flag && rel_run) begin
      side_nxt.phase  = PH_RELEASE;
      side_nxt.base   = cfg.hold_level;
      to_lvl          = cfg.final_level;
      num_nxt         = rel_t;
      den_nxt         = cfg.release_len;
    end else if (released_flag) begin
      side_nxt.phase  = PH_DONE;
      side_nxt.bypass = 1'b1;
      side_nxt.base   = '0;
    end else begin
      side_nxt.phase  = PH_SUSTAIN;
      side_nxt.bypass = 1'b1;
      side_nxt.base   = cfg.hold_level;
    end
    side_nxt.down = to_lvl < side_nxt.base;
    span_nxt      = side_nxt.down ? side_nxt.base - to_lvl : to_lvl - side_nxt.base;
    if (side_nxt.bypass) begin
      span_nxt = '0;
    end
  end

  // stage 1: decoded segment
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc;
    end
    side_r <= side_nxt;
    span_r <= span_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
  end

  // stage 2: span times numerator, split into first remainder and low bits
  assign prod = span_r * num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    beat_r.rem  <= prod[LEVEL_BITS+TIME_BITS-1:LEVEL_BITS];
    beat_r.low  <= prod[LEVEL_BITS-1:0];
    beat_r.quo  <= '0;
    beat_r.den  <= den_r;
    beat_r.side <= side_r;
  end

  assign valid = v2_r;
  assign beat  = beat_r;

endmodule

>>> rtl/core/adsr_div_cell.sv
// One restoring-division cell: takes one dividend bit, emits one quotient bit
// and hands the beat to the next cell. Depends on adsr_pkg.
module adsr_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  adsr_pkg::cell_t in_beat,
  output logic            out_valid,
  output adsr_pkg::cell_t out_beat
);
  import adsr_pkg::*;

  logic [TIME_BITS:0] trial;
  logic [TIME_BITS:0] diff;
  logic               ge;
  cell_t              beat_nxt, beat_r;
  logic               valid_r;

  // shift in next dividend bit, subtract divisor if it fits
  assign trial = {in_beat.rem, in_beat.low[LEVEL_BITS-1]};
  assign diff  = trial - {1'b0, in_beat.den};
  assign ge    = !diff[TIME_BITS];

  always_comb begin
    beat_nxt      = in_beat;
    beat_nxt.rem  = ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
    beat_nxt.low  = {in_beat.low[LEVEL_BITS-2:0], 1'b0};
    beat_nxt.quo  = {in_beat.quo[LEVEL_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    beat_r <= beat_nxt;
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

>>> rtl/core/adsr_envelope_level.sv
// Top level of the linear ADSR envelope level block: config registers,
// setup stages, divider cell chain and output register. Depends on adsr_pkg,
// adsr_setup and adsr_div_cell.
//
// Usage:
//   Input beat: drive in_elapsed, in_released_flag, in_release_offset and
//   raise start; the beat is taken at each edge where start is high and busy
//   is low. busy is high only from reset until the first edge that sees rst_n
//   high, so a new beat can be taken every cycle.
//   Result beat: out_level and out_phase are shown for one cycle with
//   out_valid high, once the beat has passed the registers named below;
//   results leave in input order, one per input. The receiver cannot stall.
//   Each beat passes the decode and multiply registers, then the divider (one
//   cell per quotient bit, LEVEL_BITS cells) and the output register; the
//   decode register loads at the accepting edge itself.
//   Config: cfg_we with cfg_idx and cfg_wdata writes one register at an edge;
//   write only while no beat is in flight. Unknown indexes are ignored.
//   Reset (synchronous, rst_n low) restores the register defaults and drops
//   every beat in flight.
module adsr_envelope_level (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [adsr_pkg::TIME_BITS-1:0]      in_elapsed,
  input  logic                                in_released_flag,
  input  logic [adsr_pkg::TIME_BITS-1:0]      in_release_offset,
  output logic                                out_valid,
  output logic [adsr_pkg::LEVEL_BITS-1:0]     out_level,
  output logic [adsr_pkg::PHASE_BITS-1:0]     out_phase,
  input  logic                                cfg_we,
  input  logic [adsr_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  logic [adsr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import adsr_pkg::*;

  cfg_t                  cfg_r, cfg_nxt;
  logic                  busy_r;
  logic                  in_acc;

  logic                  chain_v [LEVEL_BITS+1];
  cell_t                 chain_b [LEVEL_BITS+1];

  cell_t                 last;
  logic [LEVEL_BITS-1:0] level_nxt;
  logic [LEVEL_BITS-1:0] out_level_r;
  logic [PHASE_BITS-1:0] out_phase_r;
  logic                  out_valid_r;

  // config register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_ATTACK_LEN:  cfg_nxt.attack_len  = cfg_wdata[TIME_BITS-1:0];
        REG_DECAY_LEN:   cfg_nxt.decay_len   = cfg_wdata[TIME_BITS-1:0];
        REG_RELEASE_LEN: cfg_nxt.release_len = cfg_wdata[TIME_BITS-1:0];
        REG_START_LEVEL: cfg_nxt.start_level = cfg_wdata[LEVEL_BITS-1:0];
        REG_PEAK_LEVEL:  cfg_nxt.peak_level  = cfg_wdata[LEVEL_BITS-1:0];
        REG_HOLD_LEVEL:  cfg_nxt.hold_level  = cfg_wdata[LEVEL_BITS-1:0];
        REG_FINAL_LEVEL: cfg_nxt.final_level = cfg_wdata[LEVEL_BITS-1:0];
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_len  <= RST_SEG_LEN;
      cfg_r.decay_len   <= RST_SEG_LEN;
      cfg_r.release_len <= RST_SEG_LEN;
      cfg_r.start_level <= RST_START;
      cfg_r.peak_level  <= RST_PEAK;
      cfg_r.hold_level  <= RST_HOLD;
      cfg_r.final_level <= RST_FINAL;
      busy_r            <= 1'b1;
    end else begin
      cfg_r             <= cfg_nxt;
      busy_r            <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign in_acc = start && !busy_r;

  // decode and multiply
  adsr_setup u_setup (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (in_acc),
    .elapsed        (in_elapsed),
    .released_flag  (in_released_flag),
    .release_offset (in_release_offset),
    .cfg            (cfg_r),
    .valid          (chain_v[0]),
    .beat           (chain_b[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar i = 0; i < LEVEL_BITS; i++) begin : g_cell
    adsr_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_v[i]),
      .in_beat   (chain_b[i]),
      .out_valid (chain_v[i+1]),
      .out_beat  (chain_b[i+1])
    );
  end

  // apply quotient to the ramp start level, or pass the fixed level in bypass
  assign last = chain_b[LEVEL_BITS];

  always_comb begin
    priority if (last.side.bypass) begin
      level_nxt = last.side.base;
    end else if (last.side.down) begin
      level_nxt = last.side.base - last.quo;
    end else begin
      level_nxt = last.side.base + last.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain_v[LEVEL_BITS];
    end
    out_level_r <= level_nxt;
    out_phase_r <= last.side.phase;
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_phase = out_phase_r;

  // checks
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_phase == PH_DONE) |-> out_level == '0)
    else $error("done phase with nonzero level");

  a_sustain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_phase == PH_SUSTAIN) |-> out_level == cfg_r.hold_level)
    else $error("sustain level differs from hold level");

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for adsr_envelope_level: queues note beats, predicts the
// envelope level and phase of each taken beat and checks every result strobe.
// Depends on adsr_pkg and the adsr_envelope_level RTL.
module tb_top;
  import adsr_pkg::*;

  localparam int CYCLE_LIMIT       = 200000;
  localparam int BEATS_PER_SETTING = 80;
  localparam int NUM_SETTINGS      = 8;
  localparam int PAD_BITS          = CFG_DATA_BITS - LEVEL_BITS;
  localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

  typedef struct packed {
    logic [TIME_BITS-1:0] elapsed;
    logic                 released;
    logic [TIME_BITS-1:0] rel_offset;
  } note_beat_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic [PHASE_BITS-1:0] phase;
  } env_point_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [TIME_BITS-1:0]     in_elapsed = '0;
  logic                     in_released_flag = 1'b0;
  logic [TIME_BITS-1:0]     in_release_offset = '0;
  logic                     out_valid;
  logic [LEVEL_BITS-1:0]    out_level;
  logic [PHASE_BITS-1:0]    out_phase;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  cfg_t        env_cfg;      // bench copy of the envelope registers
  note_beat_t  note_q[$];    // beats waiting to be sent
  env_point_t  level_q[$];   // predicted results, oldest first
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;

  adsr_envelope_level dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_elapsed       (in_elapsed),
    .in_released_flag (in_released_flag),
    .in_release_offset(in_release_offset),
    .out_valid        (out_valid),
    .out_level        (out_level),
    .out_phase        (out_phase),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  // linear interpolation between two levels, truncating toward the start level
  function automatic logic [LEVEL_BITS-1:0] ramp_level(logic [LEVEL_BITS-1:0] from_lvl,
                                                      logic [LEVEL_BITS-1:0] to_lvl,
                                                      logic [TIME_BITS-1:0]  num,
                                                      logic [TIME_BITS-1:0]  den);
    logic [63:0] delta;
    logic [63:0] v;
    if (to_lvl >= from_lvl) begin
      delta = (64'(to_lvl - from_lvl) * 64'(num)) / 64'(den);
      v = 64'(from_lvl) + delta;
    end else begin
      delta = (64'(from_lvl - to_lvl) * 64'(num)) / 64'(den);
      v = 64'(from_lvl) - delta;
    end
    return (v > 64'(LEVEL_MAX)) ? LEVEL_MAX : v[LEVEL_BITS-1:0];
  endfunction

  // expected level and phase for one note beat under the current registers
  function automatic env_point_t predict_envelope(note_beat_t b);
    env_point_t  p;
    logic [63:0] a_len;
    logic [63:0] ad_len;
    logic [63:0] since_rel;
    a_len = 64'(env_cfg.attack_len);
    ad_len = a_len + 64'(env_cfg.decay_len);
    // release moment later than now counts as just released
    since_rel = (b.elapsed > b.rel_offset) ? 64'(b.elapsed - b.rel_offset) : 64'd0;
    if (64'(b.elapsed) <= a_len) begin
      p.phase = PH_ATTACK;
      p.level = (env_cfg.attack_len == '0) ? env_cfg.peak_level :
                ramp_level(env_cfg.start_level, env_cfg.peak_level,
                           b.elapsed, env_cfg.attack_len);
    end else if (64'(b.elapsed) <= ad_len) begin
      p.phase = PH_DECAY;
      p.level = ramp_level(env_cfg.peak_level, env_cfg.hold_level,
                           b.elapsed - env_cfg.attack_len, env_cfg.decay_len);
    end else if (!b.released) begin
      p.phase = PH_SUSTAIN;
      p.level = env_cfg.hold_level;
    end else if (since_rel < 64'(env_cfg.release_len)) begin
      p.phase = PH_RELEASE;
      p.level = ramp_level(env_cfg.hold_level, env_cfg.final_level,
                           since_rel[TIME_BITS-1:0], env_cfg.release_len);
    end else begin
      p.phase = PH_DONE;
      p.level = '0;
    end
    return p;
  endfunction

  function automatic logic [TIME_BITS-1:0] clip_time(logic [63:0] v);
    return (v > 64'(TIME_MAX)) ? TIME_MAX : v[TIME_BITS-1:0];
  endfunction

  // random beat aimed at segment interiors, boundaries and release timing
  function automatic note_beat_t shaped_beat();
    note_beat_t  b;
    logic [63:0] a_len;
    logic [63:0] ad_len;
    logic [63:0] r_len;
    logic [63:0] lag;
    logic [63:0] base;
    a_len = 64'(env_cfg.attack_len);
    ad_len = a_len + 64'(env_cfg.decay_len);
    r_len = 64'(env_cfg.release_len);
    b.elapsed = TIME_BITS'($urandom);
    b.released = 1'($urandom);
    b.rel_offset = TIME_BITS'($urandom);
    case ($urandom_range(0, 11))
      0, 1: begin
        // raw noise
      end
      2: b.elapsed = TIME_BITS'($urandom_range(0, 32'(env_cfg.attack_len)));
      3: begin
        case ($urandom_range(0, 5))
          0: b.elapsed = '0;
          1: b.elapsed = clip_time(a_len);
          2: b.elapsed = clip_time(a_len + 1);
          3: b.elapsed = clip_time(ad_len);
          4: b.elapsed = clip_time(ad_len + 1);
          default: b.elapsed = TIME_MAX;
        endcase
      end
      4: begin
        if (env_cfg.decay_len != '0)
          b.elapsed = clip_time(a_len + 64'($urandom_range(1, 32'(env_cfg.decay_len))));
      end
      5: begin
        b.elapsed = clip_time(ad_len + 1 + 64'($urandom_range(0, 5000)));
        b.released = 1'b0;
      end
      6, 7, 8: begin
        // proper release: past decay, time since release below, at or past the release length
        b.released = 1'b1;
        case ($urandom_range(0, 3))
          0: lag = (r_len == 0) ? 64'd0 : 64'($urandom_range(0, 32'(r_len - 1)));
          1: lag = (r_len == 0) ? 64'd0 : r_len - 1;
          2: lag = r_len;
          default: lag = r_len + 64'($urandom_range(0, 2000));
        endcase
        base = (lag > ad_len) ? lag : ad_len + 1;
        b.elapsed = clip_time(base + 64'($urandom_range(0, 300)));
        b.rel_offset = (64'(b.elapsed) >= lag) ? TIME_BITS'(64'(b.elapsed) - lag) : '0;
      end
      9: begin
        // release moment lies after now
        b.released = 1'b1;
        b.elapsed = clip_time(ad_len + 1 + 64'($urandom_range(0, 2000)));
        b.rel_offset = clip_time(64'(b.elapsed) + 1 + 64'($urandom_range(0, 100000)));
      end
      default: begin
        // released while still in attack or decay
        b.released = 1'b1;
        b.elapsed = TIME_BITS'($urandom_range(0, 32'(clip_time(ad_len))));
        b.rel_offset = TIME_BITS'($urandom_range(0, 32'(b.elapsed)));
      end
    endcase
    return b;
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_len();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return TIME_MAX;
      2, 3, 4: return TIME_BITS'($urandom_range(1, 64));
      5, 6: return TIME_BITS'($urandom_range(65, 5000));
      default: return TIME_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [LEVEL_BITS-1:0] rand_level();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return LEVEL_MAX;
      default: return LEVEL_BITS'($urandom);
    endcase
  endfunction

  // register settings: zero lengths, full lengths, inverted ramps, a lone long release, then random
  function automatic cfg_t pick_setting(int k);
    cfg_t c;
    c.attack_len = rand_len();
    c.decay_len = rand_len();
    c.release_len = rand_len();
    c.start_level = rand_level();
    c.peak_level = rand_level();
    c.hold_level = rand_level();
    c.final_level = rand_level();
    case (k)
      1: begin
        c.attack_len = '0;
        c.decay_len = '0;
        c.release_len = '0;
      end
      2: begin
        c.attack_len = TIME_MAX;
        c.decay_len = TIME_MAX;
        c.release_len = TIME_MAX;
        c.start_level = LEVEL_MAX;
        c.peak_level = '0;
        c.hold_level = LEVEL_MAX;
        c.final_level = '0;
      end
      3: begin
        c.attack_len = TIME_BITS'($urandom_range(1, 40));
        c.decay_len = TIME_BITS'($urandom_range(1, 40));
        c.release_len = TIME_BITS'($urandom_range(1, 40));
        c.start_level = '0;
        c.peak_level = '0;
        c.hold_level = '0;
        c.final_level = LEVEL_MAX;
      end
      4: begin
        c.attack_len = '0;
        c.decay_len = '0;
        c.release_len = TIME_MAX;
        c.hold_level = LEVEL_MAX;
        c.final_level = '0;
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  // one register write; the bench copy follows at once since nothing is in flight
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ATTACK_LEN:  env_cfg.attack_len = val[TIME_BITS-1:0];
      REG_DECAY_LEN:   env_cfg.decay_len = val[TIME_BITS-1:0];
      REG_RELEASE_LEN: env_cfg.release_len = val[TIME_BITS-1:0];
      REG_START_LEVEL: env_cfg.start_level = val[LEVEL_BITS-1:0];
      REG_PEAK_LEVEL:  env_cfg.peak_level = val[LEVEL_BITS-1:0];
      REG_HOLD_LEVEL:  env_cfg.hold_level = val[LEVEL_BITS-1:0];
      REG_FINAL_LEVEL: env_cfg.final_level = val[LEVEL_BITS-1:0];
      default: begin
      end
    endcase
  endtask

  // level registers get junk above their width to check the truncation
  task automatic apply_setting(cfg_t c);
    write_reg(REG_ATTACK_LEN, c.attack_len);
    write_reg(REG_DECAY_LEN, c.decay_len);
    write_reg(REG_RELEASE_LEN, c.release_len);
    write_reg(REG_START_LEVEL, {PAD_BITS'($urandom), c.start_level});
    write_reg(REG_PEAK_LEVEL, {PAD_BITS'($urandom), c.peak_level});
    write_reg(REG_HOLD_LEVEL, {PAD_BITS'($urandom), c.hold_level});
    write_reg(REG_FINAL_LEVEL, {PAD_BITS'($urandom), c.final_level});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // every queued beat taken and every result seen
  task automatic wait_drained();
    do @(posedge clk);
    while (note_q.size() != 0 || start || level_q.size() != 0);
  endtask

  // beats under the reset registers: 480-tick segments, 0 -> full -> 3/4 -> 0
  task automatic directed_beats();
    note_q.push_back(note_beat_t'{24'd0, 1'b0, 24'd0});
    note_q.push_back(note_beat_t'{24'd240, 1'b0, 24'd0});
    note_q.push_back(note_beat_t'{24'd480, 1'b0, 24'd0});
    note_q.push_back(note_beat_t'{24'd481, 1'b0, 24'd0});
    note_q.push_back(note_beat_t'{24'd960, 1'b0, 24'd0});
    note_q.push_back(note_beat_t'{24'd961, 1'b0, 24'd0});
    note_q.push_back(note_beat_t'{TIME_MAX, 1'b0, TIME_MAX});
    // release just now, and release moment after now
    note_q.push_back(note_beat_t'{TIME_MAX, 1'b1, TIME_MAX});
    note_q.push_back(note_beat_t'{24'd1000, 1'b1, 24'd2000});
    note_q.push_back(note_beat_t'{24'd961, 1'b1, TIME_MAX});
    // release ramp interior and its last tick, then done
    note_q.push_back(note_beat_t'{24'd1200, 1'b1, 24'd1000});
    note_q.push_back(note_beat_t'{24'd1440, 1'b1, 24'd961});
    note_q.push_back(note_beat_t'{24'd1441, 1'b1, 24'd961});
    note_q.push_back(note_beat_t'{TIME_MAX, 1'b1, 24'd0});
    // flag ignored during attack and decay
    note_q.push_back(note_beat_t'{24'd300, 1'b1, 24'd100});
    note_q.push_back(note_beat_t'{24'd700, 1'b1, 24'd500});
    note_q.push_back(note_beat_t'{24'd0, 1'b1, TIME_MAX});
    // released during decay: ramp partly over, wholly over
    note_q.push_back(note_beat_t'{24'd1000, 1'b1, 24'd700});
    note_q.push_back(note_beat_t'{24'd1000, 1'b1, 24'd500});
    note_q.push_back(note_beat_t'{24'haaaaaa, 1'b1, 24'h555555});
    note_q.push_back(note_beat_t'{24'h555555, 1'b0, 24'haaaaaa});
  endtask

  // driver: presents note_q[0], pops it and predicts when the beat is taken
  always @(posedge clk) begin : driver
    note_beat_t nb;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        nb = note_q.pop_front();
        level_q.push_back(predict_envelope(nb));
        // idle before the next beat, with runs of back-to-back beats
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else if ($urandom_range(0, 19) == 0) begin
          burst_left = $urandom_range(8, 40);
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, 17);
        end
      end
      if (start && busy) begin
        // held until taken
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (note_q.size() > 0) begin
        nb = note_q[0];
        in_elapsed <= nb.elapsed;
        in_released_flag <= nb.released;
        in_release_offset <= nb.rel_offset;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: each strobed result against the oldest prediction
  always @(posedge clk) begin : monitor
    env_point_t want;
    if (rst_n && out_valid) begin
      if (level_q.size() == 0) begin
        $error("unexpected result: level %0d phase %0d", out_level, out_phase);
        error_cnt++;
      end else begin
        want = level_q.pop_front();
        if (out_level !== want.level) begin
          $error("level mismatch: expected %0d, got %0d", want.level, out_level);
          error_cnt++;
        end
        if (out_phase !== want.phase) begin
          $error("phase mismatch: expected %0d, got %0d", want.phase, out_phase);
          error_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    env_cfg.attack_len = RST_SEG_LEN;
    env_cfg.decay_len = RST_SEG_LEN;
    env_cfg.release_len = RST_SEG_LEN;
    env_cfg.start_level = RST_START;
    env_cfg.peak_level = RST_PEAK;
    env_cfg.hold_level = RST_HOLD;
    env_cfg.final_level = RST_FINAL;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    directed_beats();
    wait_drained();
    for (int k = 1; k <= NUM_SETTINGS; k++) begin
      apply_setting(pick_setting(k));
      repeat (BEATS_PER_SETTING) note_q.push_back(shaped_beat());
      wait_drained();
    end
    // catch stray results past the pipeline depth
    repeat (LEVEL_BITS + 8) @(posedge clk);
    if (error_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> adsr_envelope_level.f
rtl/core/adsr_pkg.sv
rtl/core/adsr_setup.sv
rtl/core/adsr_div_cell.sv
rtl/core/adsr_envelope_level.sv
bench/tb_top.sv
